>>> rtl/core/rnf_pkg.sv
// Radix number formatter: shared types and constants.
// Used by the alphabet store, the iterative divider and the top level.
`default_nettype none

package rnf_pkg;

  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_APPEND  = 2'd1;
  localparam logic [1:0] OP_CONVERT = 2'd2;

  localparam logic [7:0] SYM_LOW   = 8'd32;
  localparam logic [7:0] SYM_HIGH  = 8'd126;
  localparam logic [7:0] SYM_PLUS  = 8'd43;
  localparam logic [7:0] SYM_MINUS = 8'd45;
  localparam logic [6:0] CHAR_MINUS = 7'd45;

  localparam logic [7:0] MIN_RADIX = 8'd2;

  localparam int NUM_W      = 32;
  localparam int DIV_STEP   = 4;
  localparam int DIV_CYCLES = NUM_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  typedef struct packed {
    logic [1:0]        operation;
    logic [7:0]        symbol;
    logic signed [31:0] number;
  } in_item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic       clear;
    logic       append;
    logic [7:0] sym;
  } alpha_cmd_t;

  typedef struct packed {
    logic [7:0] count;
    logic       bad;
  } alpha_stat_t;

endpackage

`default_nettype wire

>>> rtl/core/rnf_alphabet.sv
// Radix number formatter: alphabet store with duplicate and range tracking.
// Depends on rnf_pkg for the command and status structs.
`default_nettype none

module rnf_alphabet
  import rnf_pkg::*;
#(
  parameter int MAX_SYMBOLS = 128,
  localparam int ADDR_W = $clog2(MAX_SYMBOLS)
) (
  input  logic              clk,
  input  logic              rst,
  input  alpha_cmd_t        cmd,
  output alpha_stat_t       stat,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [6:0]        rd_data
);

  localparam logic [7:0] MAX_CNT = 8'(MAX_SYMBOLS);

  logic [6:0]   mem [MAX_SYMBOLS];
  logic [127:0] seen;
  logic [7:0]   count;
  logic         bad;
  logic         full;
  logic         printable;

  assign full      = (count >= MAX_CNT);
  assign printable = (cmd.sym >= SYM_LOW) && (cmd.sym <= SYM_HIGH) &&
                     (cmd.sym != SYM_PLUS) && (cmd.sym != SYM_MINUS);
  assign stat      = '{count: count, bad: bad};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bad   <= 1'b0;
      seen  <= '0;
    end else if (cmd.clear) begin
      count <= '0;
      bad   <= 1'b0;
      seen  <= '0;
    end else if (cmd.append) begin
      if (full) begin
        bad <= 1'b1;
      end else begin
        if (!printable) begin
          bad <= 1'b1;
        end else begin
          if (seen[cmd.sym[6:0]]) begin
            bad <= 1'b1;
          end
          seen[cmd.sym[6:0]] <= 1'b1;
        end
        count <= count + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append && !cmd.clear && !full) begin
      mem[count[ADDR_W-1:0]] <= cmd.sym[6:0];
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/core/rnf_divider.sv
// Radix number formatter: iterative restoring divider, DIV_STEP quotient bits per cycle.
// Depends on rnf_pkg for the step and width constants.
`default_nettype none

module rnf_divider
  import rnf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [7:0]       radix,
  output logic             busy,
  output logic             done,
  output logic [NUM_W-1:0] quotient,
  output logic [6:0]       remainder
);

  localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_CYCLES - 1);

  logic [DIV_CNT_W-1:0] cnt;
  logic [7:0]           rad;
  logic [NUM_W-1:0]     quo_next;
  logic [6:0]           rem_next;

  always_comb begin
    logic [7:0]       t;
    logic [NUM_W-1:0] q;
    logic [6:0]       r;
    q = quotient;
    r = remainder;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, q[NUM_W-1]};
      q = {q[NUM_W-2:0], 1'b0};
      if (t >= rad) begin
        r    = 7'(t - rad);
        q[0] = 1'b1;
      end else begin
        r = t[6:0];
      end
    end
    quo_next = q;
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      cnt       <= '0;
      quotient  <= dividend;
      remainder <= '0;
      rad       <= radix;
    end else if (busy) begin
      quotient  <= quo_next;
      remainder <= rem_next;
      cnt       <= cnt + 1'b1;
      if (cnt == CNT_LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/radix_number_formatter_core.sv
// Radix number formatter top level: sequencer, digit buffer and output register.
// Clear and append transactions go straight to the alphabet store. A convert transaction
// runs the divider for each digit (4 quotient bits per divider cycle), then a lookup
// and store step, then emits the characters, holding each one while the output is stalled.
// Synchronous reset empties the alphabet and idles the sequencer; memories are not swept.
`default_nettype none

module radix_number_formatter_core
  import rnf_pkg::*;
#(
  parameter int MAX_SYMBOLS = 128,
  parameter int DIGIT_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int ADDR_W = $clog2(MAX_SYMBOLS);
  localparam int DW     = $clog2(DIGIT_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_LOOK, S_STORE, S_SIGN, S_READ, S_SEND
  } state_t;

  state_t           state;
  logic             negative;
  logic [DW-1:0]    ndig;
  logic [DW-1:0]    idx;
  logic [6:0]       dbuf [DIGIT_DEPTH];
  logic [6:0]       dbuf_rd;

  alpha_cmd_t       acmd;
  alpha_stat_t      astat;
  logic [6:0]       alpha_rd;

  logic             accept;
  logic             conv_ok;
  logic             div_start;
  logic             div_busy;
  logic             div_done;
  logic [NUM_W-1:0] div_dividend;
  logic [NUM_W-1:0] div_quo;
  logic [6:0]       div_rem;
  logic [NUM_W-1:0] mag_in;
  logic             out_free;
  logic             out_load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign conv_ok  = !astat.bad && (astat.count >= MIN_RADIX);
  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && ((state == S_SIGN) || (state == S_SEND));
  assign mag_in   = in_data.number[NUM_W-1] ? (NUM_W'(0) - NUM_W'(in_data.number))
                                            : NUM_W'(in_data.number);

  assign acmd = '{clear:  accept && (in_data.operation == OP_CLEAR),
                  append: accept && (in_data.operation == OP_APPEND),
                  sym:    in_data.symbol};

  assign div_start = (accept && (in_data.operation == OP_CONVERT) && conv_ok) ||
                     ((state == S_STORE) && (div_quo != '0));
  assign div_dividend = (state == S_IDLE) ? mag_in : div_quo;

  rnf_alphabet #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_alphabet (
    .clk    (clk),
    .rst    (rst),
    .cmd    (acmd),
    .stat   (astat),
    .rd_addr(div_rem[ADDR_W-1:0]),
    .rd_data(alpha_rd)
  );

  rnf_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .radix    (astat.count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_ff @(posedge clk) begin
    if (state == S_STORE) begin
      dbuf[ndig] <= alpha_rd;
    end
    dbuf_rd <= dbuf[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      negative  <= 1'b0;
      ndig      <= '0;
      idx       <= '0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && (in_data.operation == OP_CONVERT) && conv_ok) begin
            negative <= in_data.number[NUM_W-1];
            ndig     <= '0;
            state    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_STORE;
        end
        S_STORE: begin
          ndig <= ndig + 1'b1;
          idx  <= ndig;
          if (div_quo != '0) begin
            state <= S_DIV;
          end else if (negative) begin
            state <= S_SIGN;
          end else begin
            state <= S_READ;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{character: CHAR_MINUS, last: 1'b0};
            state     <= S_READ;
          end
        end
        S_READ: begin
          state <= S_SEND;
        end
        S_SEND: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_data  <= '{character: dbuf_rd, last: (idx == '0)};
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_READ;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_bad_convert_no_work: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_data.operation == OP_CONVERT) && !conv_ok) |=> (state == S_IDLE))
    else $error("convert with invalid alphabet started work");

  a_last_ends_item: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SEND) && out_free && (idx == '0))
      |=> ((state == S_IDLE) && out_valid && out_data.last))
    else $error("final character did not close the transaction");
`endif

endmodule

`default_nettype wire
